// File: design/pspt_pkg.sv
// Shared types and constants for the pulse serial parity transceiver.
package pspt_pkg;

  // Timing, in ticks (one accepted word per tick).
  localparam logic [3:0] BIT_TICKS   = 4'd5;
  localparam logic [3:0] START_TICKS = 4'd10;
  localparam logic [3:0] GAP_TICKS   = 4'd10;
  localparam logic [3:0] CHK_TICKS   = 4'd2;

  localparam logic [7:0] TX_CHAR_RESET = 8'h54;
  localparam logic [3:0] DATA_BITS     = 4'd8;

  typedef enum logic [1:0] {
    TX_START,
    TX_DATA,
    TX_PAR,
    TX_GAP
  } tx_state_e;

  typedef enum logic [2:0] {
    RX_IDLE,
    RX_CHK1,
    RX_CHK2,
    RX_DATA,
    RX_PAR
  } rx_state_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] value;
    logic [7:0] index;
  } rx_char_t;

endpackage

// File: design/pspt_tx.sv
// Transmit frame sequencer: start pulse, 8 data bits MSB first, parity, gap.
module pspt_tx (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] tx_char_i,
  output logic       tx_level_o
);

  pspt_pkg::tx_state_e state_q, state_d;
  logic [3:0] sub_q, sub_d;
  logic [2:0] bit_q, bit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pspt_pkg::TX_START;
      sub_q   <= '0;
      bit_q   <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      sub_q   <= sub_d;
      bit_q   <= bit_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    sub_d      = sub_q + 4'd1;
    bit_d      = bit_q;
    tx_level_o = 1'b0;
    case (state_q)
      pspt_pkg::TX_START: begin
        tx_level_o = 1'b1;
        if (sub_q == pspt_pkg::START_TICKS - 4'd1) begin
          state_d = pspt_pkg::TX_DATA;
          sub_d   = '0;
          bit_d   = '0;
        end
      end
      pspt_pkg::TX_DATA: begin
        tx_level_o = tx_char_i[3'd7 - bit_q];
        if (sub_q == pspt_pkg::BIT_TICKS - 4'd1) begin
          sub_d = '0;
          bit_d = bit_q + 3'd1;
          if (bit_q == 3'd7) begin
            state_d = pspt_pkg::TX_PAR;
          end
        end
      end
      pspt_pkg::TX_PAR: begin
        tx_level_o = ^tx_char_i;
        if (sub_q == pspt_pkg::BIT_TICKS - 4'd1) begin
          state_d = pspt_pkg::TX_GAP;
          sub_d   = '0;
        end
      end
      pspt_pkg::TX_GAP: begin
        if (sub_q == pspt_pkg::GAP_TICKS - 4'd1) begin
          state_d = pspt_pkg::TX_START;
          sub_d   = '0;
        end
      end
      default: begin
        state_d = pspt_pkg::TX_START;
        sub_d   = '0;
      end
    endcase
  end

endmodule

// File: design/pspt_rx.sv
// Receive side: start check, data sampling, parity check, sequence count.
module pspt_rx (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               rx_level_i,
  output pspt_pkg::rx_char_t char_o
);

  pspt_pkg::rx_state_e mode_q, mode_d;
  logic [3:0] timer_q, timer_d;
  logic [3:0] cnt_q, cnt_d;
  logic [7:0] shift_q, shift_d;
  logic       odd_q, odd_d;
  logic [7:0] acc_q, acc_d;
  logic [3:0] timer_dec;
  logic [3:0] cnt_inc;
  logic       bit_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= pspt_pkg::RX_IDLE;
      timer_q <= '0;
      cnt_q   <= '0;
      odd_q   <= 1'b0;
      acc_q   <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      timer_q <= timer_d;
      cnt_q   <= cnt_d;
      odd_q   <= odd_d;
      acc_q   <= acc_d;
    end
  end

  // the eight data samples of a frame fill the whole byte before it is used, so no reset
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      shift_q <= shift_d;
    end
  end

  assign timer_dec = (timer_q != '0) ? timer_q - 4'd1 : '0;
  assign cnt_inc   = cnt_q + 4'd1;
  assign bit_in    = ~rx_level_i;

  always_comb begin
    mode_d  = mode_q;
    timer_d = timer_dec;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    odd_d   = odd_q;
    acc_d   = acc_q;
    char_o  = '0;
    case (mode_q)
      pspt_pkg::RX_IDLE: begin
        timer_d = timer_q;
        if (!rx_level_i) begin
          mode_d  = pspt_pkg::RX_CHK1;
          timer_d = pspt_pkg::CHK_TICKS;
        end
      end
      pspt_pkg::RX_CHK1: begin
        if (timer_dec == '0) begin
          if (!rx_level_i) begin
            mode_d  = pspt_pkg::RX_CHK2;
            timer_d = pspt_pkg::BIT_TICKS;
          end else begin
            mode_d = pspt_pkg::RX_IDLE;
          end
        end
      end
      pspt_pkg::RX_CHK2: begin
        if (timer_dec == '0) begin
          if (!rx_level_i) begin
            mode_d  = pspt_pkg::RX_DATA;
            timer_d = pspt_pkg::BIT_TICKS;
            cnt_d   = '0;
            odd_d   = 1'b0;
          end else begin
            mode_d = pspt_pkg::RX_IDLE;
          end
        end
      end
      pspt_pkg::RX_DATA: begin
        if (timer_dec == '0) begin
          shift_d = {shift_q[6:0], bit_in};
          odd_d   = odd_q ^ bit_in;
          cnt_d   = cnt_inc;
          timer_d = pspt_pkg::BIT_TICKS;
          if (cnt_inc >= pspt_pkg::DATA_BITS) begin
            mode_d = pspt_pkg::RX_PAR;
          end
        end
      end
      pspt_pkg::RX_PAR: begin
        if (timer_dec == '0) begin
          // parity bit arrives inverted: match when it differs from the line
          if (odd_q != rx_level_i) begin
            char_o.valid = 1'b1;
            char_o.value = shift_q;
            char_o.index = acc_q;
            acc_d        = acc_q + 8'd1;
          end
          // a low line here already opens the next start check
          if (!rx_level_i) begin
            mode_d  = pspt_pkg::RX_CHK1;
            timer_d = pspt_pkg::CHK_TICKS;
          end else begin
            mode_d = pspt_pkg::RX_IDLE;
          end
        end
      end
      default: begin
        mode_d = pspt_pkg::RX_IDLE;
      end
    endcase
  end

endmodule

// File: design/pulse_serial_parity_transceiver.sv
// Top level of the pulse serial parity transceiver: handshakes and result register.
//
//  channel  direction  handshake                  payload
//  cfg      in         cfg_valid_i / cfg_ready_o  cfg_data_i (tx_char)
//  in       in         in_valid_i / in_ready_o    rx_level_i
//  out      out        out_valid_o / out_ready_i  tx_level_o, char_valid_o,
//                                                 char_value_o, char_index_o
//
// One tick per accepted input word; its result word appears in the output
// register on the next cycle, one word per cycle sustained while out_ready_i is held.
// Input is taken whenever the result register is empty or being drained, so a
// stalled output holds the input off after one word.
// Configuration is always ready; tx_char resets to 0x54.
// Reset clears both frame sequencers and the character count.
module pulse_serial_parity_transceiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       rx_level_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       tx_level_o,
  output logic       char_valid_o,
  output logic [7:0] char_value_o,
  output logic [7:0] char_index_o
);

  logic [7:0] tx_char_q;
  logic       out_valid_q;
  logic       tx_level_q;
  logic       step;
  logic       tx_level;
  pspt_pkg::rx_char_t rx_char, char_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign step        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_char_q <= pspt_pkg::TX_CHAR_RESET;
    end else if (cfg_valid_i) begin
      tx_char_q <= cfg_data_i;
    end
  end

  pspt_tx u_tx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .tx_char_i  (tx_char_q),
    .tx_level_o (tx_level)
  );

  pspt_rx u_rx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .rx_level_i (rx_level_i),
    .char_o     (rx_char)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      tx_level_q <= tx_level;
      char_q     <= rx_char;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tx_level_o   = tx_level_q;
  assign char_valid_o = char_q.valid;
  assign char_value_o = char_q.value;
  assign char_index_o = char_q.index;

  // an accepted tick always yields a result word next cycle
  a_step_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("accepted word produced no result");

  // draining without refill empties the result register
  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !step) |=> !out_valid_o)
    else $error("result word repeated");

  // no character means zeroed value and index
  a_idle_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !char_valid_o) |-> (char_value_o == 8'd0 && char_index_o == 8'd0))
    else $error("stray character payload");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the pulse serial parity transceiver: line ticks in, tick results out.
module testbench;

  localparam int CLK_PERIOD   = 10;
  localparam int BIT_LEN      = int'(pspt_pkg::BIT_TICKS);
  localparam int START_LEN    = int'(pspt_pkg::START_TICKS);
  localparam int GAP_LEN      = int'(pspt_pkg::GAP_TICKS);
  localparam int FRAME_LEN    = START_LEN + 9 * BIT_LEN + GAP_LEN;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 215;
  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 80;
  localparam int LONG_HOLD_AT = 600;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic               tx_level;
    pspt_pkg::rx_char_t chr;
  } tick_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = 8'h00;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       rx_level_i = 1'b1;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       tx_level_o;
  logic       char_valid_o;
  logic [7:0] char_value_o;
  logic [7:0] char_index_o;

  pulse_serial_parity_transceiver u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_level_i   (rx_level_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .tx_level_o   (tx_level_o),
    .char_valid_o (char_valid_o),
    .char_value_o (char_value_o),
    .char_index_o (char_index_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // line samples still to be offered, and results owed by the block
  logic         rx_pending[$];
  tick_result_t tick_expect[$];
  int           words_queued = 0;
  int           words_taken  = 0;
  int           faults       = 0;
  bit           in_acc = 1'b0, out_acc = 1'b0, cfg_acc = 1'b0;
  bit           no_idle = 1'b0;

  // link state mirror
  logic [7:0]          tx_byte    = pspt_pkg::TX_CHAR_RESET;
  int                  tx_phase   = 0;
  pspt_pkg::rx_state_e rx_mode    = pspt_pkg::RX_IDLE;
  logic [3:0]          rx_timer   = '0;
  logic [3:0]          rx_bits    = '0;
  logic [7:0]          rx_shift   = '0;
  logic                rx_odd     = 1'b0;
  logic [7:0]          char_count = '0;

  function automatic logic tx_drive();
    int p;
    p = tx_phase;
    if (p < START_LEN) return 1'b1;
    p -= START_LEN;
    if (p < 8 * BIT_LEN) return tx_byte[7 - p / BIT_LEN];
    p -= 8 * BIT_LEN;
    if (p < BIT_LEN) return ^tx_byte;
    return 1'b0;
  endfunction

  function automatic tick_result_t link_tick(logic rx);
    tick_result_t r;
    logic         b;
    r = '0;
    r.tx_level = tx_drive();
    tx_phase = (tx_phase + 1 >= FRAME_LEN) ? 0 : tx_phase + 1;
    if (rx_mode == pspt_pkg::RX_IDLE) begin
      if (!rx) begin
        rx_mode  = pspt_pkg::RX_CHK1;
        rx_timer = pspt_pkg::CHK_TICKS;
      end
    end else begin
      if (rx_timer != 0) rx_timer--;
      if (rx_timer == 0) begin
        case (rx_mode)
          pspt_pkg::RX_CHK1: begin
            if (!rx) begin
              rx_mode  = pspt_pkg::RX_CHK2;
              rx_timer = pspt_pkg::BIT_TICKS;
            end else begin
              rx_mode = pspt_pkg::RX_IDLE;
            end
          end
          pspt_pkg::RX_CHK2: begin
            if (!rx) begin
              rx_mode  = pspt_pkg::RX_DATA;
              rx_timer = pspt_pkg::BIT_TICKS;
              rx_bits  = '0;
              rx_odd   = 1'b0;
            end else begin
              rx_mode = pspt_pkg::RX_IDLE;
            end
          end
          pspt_pkg::RX_DATA: begin
            b        = ~rx;
            rx_shift = {rx_shift[6:0], b};
            rx_odd   = rx_odd ^ b;
            rx_bits  = rx_bits + 4'd1;
            rx_timer = pspt_pkg::BIT_TICKS;
            if (rx_bits >= pspt_pkg::DATA_BITS) rx_mode = pspt_pkg::RX_PAR;
          end
          default: begin
            // parity sample; a low line here already opens the next detection
            if (rx_odd != rx) begin
              r.chr.valid = 1'b1;
              r.chr.value = rx_shift;
              r.chr.index = char_count;
              char_count  = char_count + 8'd1;
            end
            if (!rx) begin
              rx_mode  = pspt_pkg::RX_CHK1;
              rx_timer = pspt_pkg::CHK_TICKS;
            end else begin
              rx_mode = pspt_pkg::RX_IDLE;
            end
          end
        endcase
      end
    end
    return r;
  endfunction

  task automatic push_level(logic lvl, int n);
    repeat (n) begin
      rx_pending.push_back(lvl);
      words_queued++;
    end
  endtask

  // received frame is the inverse of what the emitter sends
  task automatic push_frame(logic [7:0] chr, bit bad_par, int gap);
    push_level(1'b0, START_LEN);
    for (int i = 7; i >= 0; i--) push_level(~chr[i], BIT_LEN);
    push_level(~(^chr ^ bad_par), BIT_LEN);
    push_level(1'b1, gap);
  endtask

  // monitor: predicts on each accepted line word, checks each result word
  always @(posedge clk_i) begin
    tick_result_t want;
    if (!rst_ni) begin
      in_acc  = 1'b0;
      out_acc = 1'b0;
      cfg_acc = 1'b0;
    end else begin
      in_acc  = in_valid_i && in_ready_o;
      out_acc = out_valid_o && out_ready_i;
      cfg_acc = cfg_valid_i && cfg_ready_o;
      if (cfg_acc) tx_byte = cfg_data_i;
      if (in_acc) begin
        tick_expect.push_back(link_tick(rx_level_i));
        words_taken++;
      end
      if (out_acc) begin
        if (tick_expect.size() == 0) begin
          faults++;
          if (faults <= REPORT_MAX)
            $display("%0t: result word with nothing expected", $realtime);
        end else begin
          want = tick_expect.pop_front();
          if (tx_level_o !== want.tx_level || char_valid_o !== want.chr.valid ||
              char_value_o !== want.chr.value || char_index_o !== want.chr.index) begin
            faults++;
            if (faults <= REPORT_MAX)
              $display({"%0t: exp tx=%0b vld=%0b chr=%02h idx=%0d, ",
                        "got tx=%0b vld=%0b chr=%02h idx=%0d"},
                       $realtime, want.tx_level, want.chr.valid, want.chr.value,
                       want.chr.index, tx_level_o, char_valid_o, char_value_o, char_index_o);
          end
        end
      end
    end
  end

  // driver: offers line words from the pending queue, idling in bursts
  int src_left = 0;
  bit src_idle = 1'b0;

  always @(negedge clk_i) begin
    logic nv, nd;
    nv = in_valid_i;
    nd = rx_level_i;
    if (!rst_ni) begin
      nv = 1'b0;
    end else if (!(in_valid_i && !in_acc)) begin
      nv = 1'b0;
      if (src_left == 0) begin
        if (!no_idle && $urandom_range(0, 3) == 0) begin
          src_idle = 1'b1;
          src_left = $urandom_range(1, 8);
        end else begin
          src_idle = 1'b0;
          src_left = $urandom_range(1, 40);
        end
      end
      src_left--;
      if (no_idle) src_idle = 1'b0;
      if (!src_idle && rx_pending.size() > 0) begin
        nv = 1'b1;
        nd = rx_pending.pop_front();
      end
    end
    in_valid_i <= nv;
    rx_level_i <= nd;
  end

  // result sink: random stalls plus one long hold-off to back the block up
  int snk_left  = 0;
  bit snk_idle  = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk_i) begin
    logic nr;
    if (!rst_ni) begin
      nr = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      nr = 1'b0;
    end else if (!hold_done && words_taken >= LONG_HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      nr = 1'b0;
    end else begin
      if (snk_left == 0) begin
        if (!no_idle && $urandom_range(0, 3) == 0) begin
          snk_idle = 1'b1;
          snk_left = $urandom_range(1, 8);
        end else begin
          snk_idle = 1'b0;
          snk_left = $urandom_range(1, 40);
        end
      end
      snk_left--;
      if (no_idle) snk_idle = 1'b0;
      nr = !snk_idle;
    end
    out_ready_i <= nr;
  end

  // watchdog on cycles without any handshake
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
      $display("** pulse_serial_parity_transceiver: FAILED **");
      $finish;
    end
  end

  initial begin
    int         r;
    int         idx;
    logic [7:0] chr;
    logic [7:0] cval;
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // short checks: idle line, start check failing at each stage
    push_level(1'b1, 3);
    push_level(1'b0, 1);
    push_level(1'b1, 2);
    push_level(1'b0, 7);
    push_level(1'b1, 3);
    // byte extremes, one with a parity error, back to back
    push_frame(8'h00, 1'b0, 0);
    push_frame(8'hFF, 1'b1, 4);
    push_frame(8'hFF, 1'b0, GAP_LEN);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        case (ph)
          1:       cval = 8'h00;
          2:       cval = 8'hFF;
          3:       cval = 8'h01;
          4:       cval = 8'h80;
          default: cval = 8'($urandom_range(0, 255));
        endcase
        @(negedge clk_i);
        cfg_valid_i <= 1'b1;
        cfg_data_i  <= cval;
        do @(negedge clk_i); while (!cfg_acc);
        cfg_valid_i <= 1'b0;
      end
      if (ph == PHASES - 1) no_idle = 1'b1;

      while (rx_pending.size() < PHASE_WORDS) begin
        r = $urandom_range(0, 9);
        case ($urandom_range(0, 7))
          0:       chr = 8'h00;
          1:       chr = 8'hFF;
          default: chr = 8'($urandom_range(0, 255));
        endcase
        if (r < 7) begin
          push_frame(chr, $urandom_range(0, 4) == 0, $urandom_range(0, 12));
        end else if (r == 7) begin
          repeat ($urandom_range(1, 20)) push_level(1'($urandom_range(0, 1)), 1);
        end else if (r == 8) begin
          // frame with one corrupted tick
          idx = $urandom_range(0, 6);
          push_frame(chr, 1'b0, idx);
          idx = rx_pending.size() - $urandom_range(1, FRAME_LEN - GAP_LEN + idx);
          rx_pending[idx] = ~rx_pending[idx];
        end else begin
          // false start that dies in one of the checks
          push_level(1'b0, $urandom_range(1, 7));
          push_level(1'b1, $urandom_range(1, 6));
        end
      end

      // sender pauses until the block has delivered everything
      do @(negedge clk_i); while (words_taken != words_queued || tick_expect.size() != 0);
    end

    repeat (3) @(negedge clk_i);
    faults += tick_expect.size();
    if (faults == 0)
      $display("** pulse_serial_parity_transceiver: PASSED **");
    else
      $display("** pulse_serial_parity_transceiver: FAILED **");
    $finish;
  end

endmodule
